// ===== rtl/stqu_pkg.sv =====
// stqu_pkg: shared types and constants for the smallest-three quaternion unpack unit
// depends on nothing; used by every module under rtl
`default_nettype none

package stqu_pkg;

    localparam int FIELD_W    = 14;
    localparam int SMALL_W    = 15;
    localparam int SQ_W       = 30;
    localparam int PROD_W     = 46;
    localparam int ACC_W      = 32;
    localparam int COMP_W     = 16;
    localparam int SQRT_CELLS = 16;

    localparam logic [30:0]        SQRT2_Q30    = 31'd1518500250;
    localparam logic [PROD_W-1:0]  ROUND_HALF   = PROD_W'(64'd1 << 29);
    localparam logic [SMALL_W-1:0] FIELD_OFFSET = 15'd16384;
    localparam logic [SQ_W-1:0]    UNIT_SQ      = 30'd536870912;
    localparam logic [ACC_W-1:0]   MAX_MAG      = 32'd32767;

    localparam logic [1:0] IDX_0 = 2'd0;
    localparam logic [1:0] IDX_1 = 2'd1;
    localparam logic [1:0] IDX_2 = 2'd2;
    localparam logic [1:0] IDX_3 = 2'd3;

    typedef struct packed {
        logic              sl;
        logic [1:0]        big;
        logic [COMP_W-1:0] qb;
        logic [COMP_W-1:0] qa;
        logic [COMP_W-1:0] qc;
    } side_t;

    typedef struct packed {
        logic [ACC_W-1:0] x;
        logic [ACC_W-1:0] res;
        side_t            side;
    } cell_t;

endpackage

`default_nettype wire

// ===== rtl/stqu_front.sv =====
// stqu_front: field decode, squares and sqrt2 scaling, sum of squares (three stages)
// depends on stqu_pkg
`default_nettype none

module stqu_front
    import stqu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] word_a,
    input  wire logic [15:0] word_b,
    input  wire logic [15:0] word_c,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output cell_t            dn_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    // stage 1 payload
    logic [SMALL_W-1:0] na_reg, nb_reg, nc_reg;
    logic               sl1_reg;
    logic [1:0]         big1_reg;
    logic [SMALL_W-1:0] na_next, nb_next, nc_next;

    // stage 2 payload
    logic [SQ_W-1:0]    sqa_reg, sqb_reg, sqc_reg;
    logic [PROD_W-1:0]  pa_reg, pb_reg, pc_reg;
    logic               nega_reg, negb_reg, negc_reg;
    logic               sl2_reg;
    logic [1:0]         big2_reg;
    logic [SMALL_W-1:0] ma, mb, mc;

    // stage 3 payload
    cell_t              d3_reg;
    cell_t              d3_next;
    logic [SQ_W-1:0]    sum_sq;
    logic [SQ_W-1:0]    rest;
    logic [COMP_W-1:0]  qa_mag, qb_mag, qc_mag;
    logic [PROD_W-1:0]  ra, rb, rc;

    assign r3       = !v3_reg || dn_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;
    assign dn_valid = v3_reg;
    assign dn_data  = d3_reg;

    function automatic logic [SMALL_W-1:0] form_small(input logic [FIELD_W-1:0] f,
                                                      input logic s);
        logic [SMALL_W-1:0] fe;
        fe = {1'b0, f};
        return s ? (SMALL_W'(0) - fe) : (fe - FIELD_OFFSET);
    endfunction

    function automatic logic [SMALL_W-1:0] mag_of(input logic [SMALL_W-1:0] n);
        return n[SMALL_W-1] ? (SMALL_W'(0) - n) : n;
    endfunction

    always_comb
    begin
        na_next = form_small(word_a[14:1], word_a[15]);
        nb_next = form_small(word_b[13:0], word_b[14]);
        nc_next = form_small(word_c[15:2], word_a[0]);
    end

    assign ma = mag_of(na_reg);
    assign mb = mag_of(nb_reg);
    assign mc = mag_of(nc_reg);

    always_comb
    begin
        sum_sq = sqa_reg + sqb_reg + sqc_reg;
        rest   = (sum_sq > UNIT_SQ) ? SQ_W'(0) : (UNIT_SQ - sum_sq);
        ra     = (pa_reg + ROUND_HALF) >> 30;
        rb     = (pb_reg + ROUND_HALF) >> 30;
        rc     = (pc_reg + ROUND_HALF) >> 30;
        qa_mag = ra[COMP_W-1:0];
        qb_mag = rb[COMP_W-1:0];
        qc_mag = rc[COMP_W-1:0];
        d3_next.x        = {1'b0, rest, 1'b0};
        d3_next.res      = ACC_W'(0);
        d3_next.side.sl  = sl2_reg;
        d3_next.side.big = big2_reg;
        d3_next.side.qa  = nega_reg ? (COMP_W'(0) - qa_mag) : qa_mag;
        d3_next.side.qb  = negb_reg ? (COMP_W'(0) - qb_mag) : qb_mag;
        d3_next.side.qc  = negc_reg ? (COMP_W'(0) - qc_mag) : qc_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            na_reg   <= na_next;
            nb_reg   <= nb_next;
            nc_reg   <= nc_next;
            sl1_reg  <= word_b[15];
            big1_reg <= word_c[1:0];
        end
        if (r2 && v1_reg)
        begin
            sqa_reg  <= SQ_W'(ma) * SQ_W'(ma);
            sqb_reg  <= SQ_W'(mb) * SQ_W'(mb);
            sqc_reg  <= SQ_W'(mc) * SQ_W'(mc);
            pa_reg   <= PROD_W'(ma) * PROD_W'(SQRT2_Q30);
            pb_reg   <= PROD_W'(mb) * PROD_W'(SQRT2_Q30);
            pc_reg   <= PROD_W'(mc) * PROD_W'(SQRT2_Q30);
            nega_reg <= na_reg[SMALL_W-1];
            negb_reg <= nb_reg[SMALL_W-1];
            negc_reg <= nc_reg[SMALL_W-1];
            sl2_reg  <= sl1_reg;
            big2_reg <= big1_reg;
        end
        if (r3 && v2_reg)
        begin
            d3_reg <= d3_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stqu_sqrt_cell.sv =====
// stqu_sqrt_cell: one restoring square-root step for a fixed bit position, registered
// depends on stqu_pkg
`default_nettype none

module stqu_sqrt_cell
    import stqu_pkg::*;
#(
    parameter int BIT_POS = 30
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_ready,
    input  wire cell_t up_data,
    output logic       dn_valid,
    input  wire logic  dn_ready,
    output cell_t      dn_data
);

    localparam logic [ACC_W-1:0] BIT = ACC_W'(64'd1 << BIT_POS);

    logic             v_reg;
    cell_t            d_reg;
    cell_t            d_next;
    logic [ACC_W-1:0] trial;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

    always_comb
    begin
        trial  = up_data.res + BIT;
        d_next = up_data;
        if (up_data.x >= trial)
        begin
            d_next.x   = up_data.x - trial;
            d_next.res = (up_data.res >> 1) + BIT;
        end
        else
        begin
            d_next.res = up_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            d_reg <= d_next;
    end

endmodule

`default_nettype wire

// ===== rtl/stqu_back.sv =====
// stqu_back: root rounding, saturation, sign and slot placement into the output register
// depends on stqu_pkg
`default_nettype none

module stqu_back
    import stqu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire cell_t              up_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [COMP_W-1:0] comp0,
    output logic signed [COMP_W-1:0] comp1,
    output logic signed [COMP_W-1:0] comp2,
    output logic signed [COMP_W-1:0] comp3
);

    logic              v_reg;
    logic [COMP_W-1:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic [COMP_W-1:0] c0_next, c1_next, c2_next, c3_next;
    logic [ACC_W-1:0]  r_round;
    logic [ACC_W-1:0]  r_sat;
    logic [COMP_W-1:0] big_val;

    assign up_ready  = !v_reg || !out_stall;
    assign out_valid = v_reg;
    assign comp0     = c0_reg;
    assign comp1     = c1_reg;
    assign comp2     = c2_reg;
    assign comp3     = c3_reg;

    always_comb
    begin
        r_round = (up_data.x > up_data.res) ? (up_data.res + ACC_W'(1)) : up_data.res;
        r_sat   = (r_round > MAX_MAG) ? MAX_MAG : r_round;
        big_val = up_data.side.sl ? r_sat[COMP_W-1:0]
                                  : (COMP_W'(0) - r_sat[COMP_W-1:0]);
        c0_next = up_data.side.qb;
        c1_next = up_data.side.qa;
        c2_next = up_data.side.qc;
        c3_next = big_val;
        case (up_data.side.big)
            IDX_0:
            begin
                c0_next = big_val;
                c1_next = up_data.side.qb;
                c2_next = up_data.side.qa;
                c3_next = up_data.side.qc;
            end
            IDX_1:
            begin
                c0_next = up_data.side.qb;
                c1_next = big_val;
                c2_next = up_data.side.qa;
                c3_next = up_data.side.qc;
            end
            IDX_2:
            begin
                c0_next = up_data.side.qb;
                c1_next = up_data.side.qa;
                c2_next = big_val;
                c3_next = up_data.side.qc;
            end
            IDX_3:
            begin
                c0_next = up_data.side.qb;
                c1_next = up_data.side.qa;
                c2_next = up_data.side.qc;
                c3_next = big_val;
            end
            default:
            begin
                c0_next = up_data.side.qb;
                c1_next = up_data.side.qa;
                c2_next = up_data.side.qc;
                c3_next = big_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/smallest_three_quat_unpack_unit.sv =====
// smallest_three_quat_unpack_unit: top level, front stages, square-root cell chain, back stage
// depends on stqu_pkg, stqu_front, stqu_sqrt_cell, stqu_back
//
// Unpacks one 48-bit smallest-three rotation (word_a, word_b, word_c) per transaction into
// four Q1.15 quaternion components. A new transaction is accepted every cycle while in_stall
// is low. Each one passes 20 registers: three front stages (decode, squares and sqrt2
// scaling, sum of squares), a chain of 16 square-root cells retiring one root bit each, and
// the output register. Every stage has its own valid bit, so an output stall only holds back
// the stages that are already full.
`default_nettype none

module smallest_three_quat_unpack_unit
    import stqu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        word_a,
    input  wire logic [15:0]        word_b,
    input  wire logic [15:0]        word_c,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [COMP_W-1:0] comp0,
    output logic signed [COMP_W-1:0] comp1,
    output logic signed [COMP_W-1:0] comp2,
    output logic signed [COMP_W-1:0] comp3
);

    logic  in_ready;
    logic  ch_valid [SQRT_CELLS+1];
    logic  ch_ready [SQRT_CELLS+1];
    cell_t ch_data  [SQRT_CELLS+1];

    assign in_stall = !in_ready;

    stqu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .word_a   (word_a),
        .word_b   (word_b),
        .word_c   (word_c),
        .dn_valid (ch_valid[0]),
        .dn_ready (ch_ready[0]),
        .dn_data  (ch_data[0])
    );

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_cell
        stqu_sqrt_cell #(
            .BIT_POS (2 * (SQRT_CELLS - 1 - i))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ch_valid[i]),
            .up_ready (ch_ready[i]),
            .up_data  (ch_data[i]),
            .dn_valid (ch_valid[i+1]),
            .dn_ready (ch_ready[i+1]),
            .dn_data  (ch_data[i+1])
        );
    end

    stqu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (ch_valid[SQRT_CELLS]),
        .up_ready  (ch_ready[SQRT_CELLS]),
        .up_data   (ch_data[SQRT_CELLS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .comp0     (comp0),
        .comp1     (comp1),
        .comp2     (comp2),
        .comp3     (comp3)
    );

    // no component ever reaches the most negative code
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (comp0 != 16'sh8000 && comp1 != 16'sh8000 &&
                       comp2 != 16'sh8000 && comp3 != 16'sh8000))
        else $error("component at most negative code");

    // input is held back only by a waiting output transaction
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // one root bit per cell: the first cell result never exceeds one bit set
    a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[1] |-> $onehot0(ch_data[1].res))
        else $error("first root cell holds more than one bit");

endmodule

`default_nettype wire
